// ----- src/kmna_pkg.sv -----
`timescale 1ns / 1ps
package kmna_pkg;

    localparam int unsigned WeightFracBits = 16;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Result of one pass through the shared divider.
    typedef struct packed {
        logic        done;
        logic        big;   // quotient did not fit in 48 bits
        logic [47:0] quot;
    } t_div_res;

    // Result of one pass through the square-root unit.
    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_res;

endpackage

// ----- src/kmna_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The numerator is loaded
// left-aligned; once its bits are used up, zeros are shifted in.
module kmna_div
    import kmna_pkg::*;
#(
    parameter int unsigned CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_num,
    input  logic [63:0]      i_den,
    input  logic [CNT_W-1:0] i_iters,
    output t_div_res         o_res
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rem;
    logic [63:0]      r_num;
    logic [63:0]      r_den;
    logic [47:0]      r_q;
    logic             r_big;
    logic             r_done;

    logic [64:0] rem_sh;
    logic        ge;
    logic [64:0] rem_sub;

    assign rem_sh  = {r_rem, r_num[63]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_q    <= '0;
                r_big  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
                r_num <= {r_num[62:0], 1'b0};
                r_q   <= {r_q[46:0], ge};
                r_big <= r_big | r_q[47];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_res.quot = r_q;

endmodule

// ----- src/kmna_sqrt.sv -----
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 48-bit value, one result bit per cycle.
module kmna_sqrt
    import kmna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_x,
    output t_sqrt_res   o_res
);

    logic        r_busy;
    logic        r_done;
    logic [49:0] r_x;
    logic [49:0] r_res;
    logic [49:0] r_bit;

    logic [49:0] trial;
    logic        ge;

    assign trial = r_res + r_bit;
    assign ge    = r_x >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= {2'b00, i_x};
                r_res  <= '0;
                r_bit  <= 50'd1 << 48;
            end else if (r_busy) begin
                r_x   <= ge ? r_x - trial : r_x;
                r_res <= ge ? (r_res >> 1) + r_bit : r_res >> 1;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[31:0];

endmodule

// ----- src/kaplan_meier_nelson_aalen.sv -----
`timescale 1ns / 1ps
// Timing: an out-of-order point shows its result in the cycle after the transfer.
// A normal point runs the survival, Greenwood, hazard and variance divisions and
// both square roots; one with zero at risk runs only the square roots, and one
// whose events reach the number at risk skips the survival and Greenwood steps.
// Throughput: one point at a time; the next transfer can come in the cycle after the
// result transfer, so the serial divider and root unit bound how often points are taken.
// Reset: synchronous, active low; group count returns to 1 and all sums clear.
module kaplan_meier_nelson_aalen
    import kmna_pkg::*;
#(
    parameter int unsigned WEIGHT_FRAC_BITS = WeightFracBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_group_count_we,
    input  logic [15:0] i_group_count,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_group_id,
    input  logic [31:0] i_event_weight,
    input  logic [31:0] i_risk_weight,
    input  logic        i_last_point,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_survival,
    output logic [31:0] o_survival_std,
    output logic [31:0] o_cum_hazard,
    output logic [31:0] o_cum_hazard_std,
    output logic        o_saturated,
    output logic        o_unassigned
);

    // Iteration counts of the divider. The variance terms divide d * 2^(F+32)
    // by a 64-bit product; the hazard term divides d * 2^16 by n; the survival
    // update divides a 64-bit product by n.
    localparam int unsigned ItersVar = 64 + WEIGHT_FRAC_BITS;
    localparam int unsigned CntW     = $clog2(ItersVar + 1);

    // Sequencer codes.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL_S = 4'd1;
    localparam logic [3:0] ST_DIV_S = 4'd2;
    localparam logic [3:0] ST_MUL_G = 4'd3;
    localparam logic [3:0] ST_DIV_G = 4'd4;
    localparam logic [3:0] ST_DIV_H = 4'd5;
    localparam logic [3:0] ST_MUL_V = 4'd6;
    localparam logic [3:0] ST_DIV_V = 4'd7;
    localparam logic [3:0] ST_SQ_G  = 4'd8;
    localparam logic [3:0] ST_SQ_V  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]  r_state, n_state;
    logic        r_go;

    logic [15:0] r_count;
    logic [15:0] r_cur;
    logic        r_stuck;
    logic [31:0] r_surv;
    logic [47:0] r_green;
    logic [47:0] r_haz;
    logic [47:0] r_var;
    logic        r_satf;

    logic [31:0] r_d;
    logic [31:0] r_n;
    logic        r_last;
    logic [63:0] r_prod;
    logic [31:0] r_root_g;

    // One shared 32x32 multiplier; its product is always registered.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        case (r_state)
            ST_MUL_S: begin mul_a = r_surv; mul_b = r_n - r_d; end
            ST_MUL_G: begin mul_a = r_n;    mul_b = r_n - r_d; end
            default:  begin mul_a = r_n;    mul_b = r_n;       end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Divider operands; the divider samples them only when started.
    logic            div_start;
    logic [63:0]     div_num, div_den;
    logic [CntW-1:0] div_iters;
    t_div_res        div_res;

    always_comb begin
        case (r_state)
            ST_DIV_S: begin
                div_num   = r_prod;
                div_den   = {32'd0, r_n};
                div_iters = CntW'(64);
            end
            ST_DIV_H: begin
                div_num   = {r_d, 32'd0};
                div_den   = {32'd0, r_n};
                div_iters = CntW'(48);
            end
            default: begin
                div_num   = {r_d, 32'd0};
                div_den   = r_prod;
                div_iters = CntW'(ItersVar);
            end
        endcase
    end

    assign div_start = r_go && (r_state == ST_DIV_S || r_state == ST_DIV_G ||
                                r_state == ST_DIV_H || r_state == ST_DIV_V);

    kmna_div #(.CNT_W(CntW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_iters (div_iters),
        .o_res   (div_res)
    );

    logic        sq_start;
    logic [47:0] sq_x;
    t_sqrt_res   sq_res;

    assign sq_start = r_go && (r_state == ST_SQ_G || r_state == ST_SQ_V);
    assign sq_x     = (r_state == ST_SQ_G) ? r_green : r_var;

    kmna_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_res   (sq_res)
    );

    // Quotient of a variance or hazard term, saturated to 48 bits, and the
    // running sum that it is added to.
    logic [47:0] term;
    logic [47:0] acc;
    logic [48:0] acc_sum;
    logic [47:0] acc_sat;
    logic        acc_ovf;

    assign term = div_res.big ? SUM_MAX : div_res.quot;
    always_comb begin
        case (r_state)
            ST_DIV_G: acc = r_green;
            ST_DIV_H: acc = r_haz;
            default:  acc = r_var;
        endcase
    end
    assign acc_sum = {1'b0, acc} + {1'b0, term};
    assign acc_ovf = acc_sum[48] || div_res.big;
    assign acc_sat = acc_sum[48] ? SUM_MAX : acc_sum[47:0];

    // Group ordering decision for the item being transferred.
    logic in_fire;
    logic same_grp, new_grp, stuck_now;

    assign in_fire   = i_in_valid && o_in_ready;
    assign same_grp  = (r_cur != 16'd0) && (i_group_id == r_cur);
    assign new_grp   = (i_group_id > r_cur) && (i_group_id <= r_count);
    assign stuck_now = r_stuck || !(same_grp || new_grp);

    // The hazard is reported as Q16.16 and saturates when it outgrows 32 bits.
    logic haz_big;
    logic flag_fin;
    assign haz_big  = r_haz[47:32] != 16'd0;
    assign flag_fin = r_satf || haz_big;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (stuck_now) begin
                        n_state = ST_OUT;
                    end else if (i_risk_weight == 32'd0) begin
                        n_state = ST_SQ_G;
                    end else if (i_event_weight >= i_risk_weight) begin
                        n_state = ST_DIV_H;
                    end else begin
                        n_state = ST_MUL_S;
                    end
                end
            end
            ST_MUL_S: n_state = ST_DIV_S;
            ST_DIV_S: if (div_res.done) n_state = ST_MUL_G;
            ST_MUL_G: n_state = ST_DIV_G;
            ST_DIV_G: if (div_res.done) n_state = ST_DIV_H;
            ST_DIV_H: if (div_res.done) n_state = ST_MUL_V;
            ST_MUL_V: n_state = ST_DIV_V;
            ST_DIV_V: if (div_res.done) n_state = ST_SQ_G;
            ST_SQ_G:  if (sq_res.done) n_state = ST_SQ_V;
            ST_SQ_V:  if (sq_res.done) n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_count     <= 16'd1;
            r_cur       <= 16'd0;
            r_stuck     <= 1'b0;
            r_surv      <= ONE_Q31;
            r_green     <= '0;
            r_haz       <= '0;
            r_var       <= '0;
            r_satf      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Every unit is started on the first cycle of its state.
            r_go    <= n_state != r_state;

            if (i_group_count_we) begin
                r_count <= i_group_count;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_d    <= i_event_weight;
                        r_n    <= i_risk_weight;
                        r_last <= i_last_point;
                        if (stuck_now) begin
                            // Out-of-order points get the default result; the
                            // final point of the set clears the stuck state.
                            r_stuck          <= !i_last_point;
                            o_out_valid      <= 1'b1;
                            o_survival       <= ONE_Q31;
                            o_survival_std   <= 32'd0;
                            o_cum_hazard     <= 32'd0;
                            o_cum_hazard_std <= 32'd0;
                            o_saturated      <= 1'b0;
                            o_unassigned     <= 1'b1;
                            if (i_last_point) begin
                                r_cur   <= 16'd0;
                                r_surv  <= ONE_Q31;
                                r_green <= '0;
                                r_haz   <= '0;
                                r_var   <= '0;
                                r_satf  <= 1'b0;
                            end
                        end else begin
                            if (!same_grp) begin
                                r_cur <= i_group_id;
                                r_haz <= '0;
                                r_var <= '0;
                            end
                            // All events at risk: survival drops to zero and
                            // the Greenwood sum saturates.
                            if (i_risk_weight != 32'd0 &&
                                i_event_weight >= i_risk_weight) begin
                                r_surv  <= 32'd0;
                                r_green <= SUM_MAX;
                                r_satf  <= 1'b1;
                            end else if (!same_grp) begin
                                r_surv  <= ONE_Q31;
                                r_green <= '0;
                                r_satf  <= 1'b0;
                            end
                        end
                    end
                end
                ST_MUL_S, ST_MUL_G, ST_MUL_V: begin
                    r_prod <= mul_p;
                end
                ST_DIV_S: begin
                    if (div_res.done) begin
                        r_surv <= div_res.quot[31:0];
                    end
                end
                ST_DIV_G: begin
                    if (div_res.done) begin
                        r_green <= acc_sat;
                        r_satf  <= r_satf | acc_ovf;
                    end
                end
                ST_DIV_H: begin
                    if (div_res.done) begin
                        r_haz  <= acc_sat;
                        r_satf <= r_satf | acc_ovf;
                    end
                end
                ST_DIV_V: begin
                    if (div_res.done) begin
                        r_var  <= acc_sat;
                        r_satf <= r_satf | acc_ovf;
                    end
                end
                ST_SQ_G: begin
                    if (sq_res.done) begin
                        r_root_g <= sq_res.root;
                    end
                end
                ST_SQ_V: begin
                    if (sq_res.done) begin
                        o_out_valid      <= 1'b1;
                        o_survival       <= r_surv;
                        o_survival_std   <= r_root_g;
                        o_cum_hazard     <= haz_big ? 32'hFFFF_FFFF : r_haz[31:0];
                        o_cum_hazard_std <= sq_res.root;
                        o_saturated      <= flag_fin;
                        o_unassigned     <= 1'b0;
                        r_satf           <= r_last ? 1'b0 : flag_fin;
                        // The final point of a data set returns the state to
                        // its reset values once its result is captured.
                        if (r_last) begin
                            r_cur   <= 16'd0;
                            r_stuck <= 1'b0;
                            r_surv  <= ONE_Q31;
                            r_green <= '0;
                            r_haz   <= '0;
                            r_var   <= '0;
                        end
                    end
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = r_state == ST_IDLE;

endmodule

// ----- src/kmna_chk.sv -----
`timescale 1ns / 1ps
module kmna_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_survival,
    input logic [31:0] o_survival_std,
    input logic [31:0] o_cum_hazard,
    input logic [31:0] o_cum_hazard_std,
    input logic        o_saturated,
    input logic        o_unassigned
);

    // A pending result is never dropped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // Only one point is in the block at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while result pending");

    // Survival never exceeds one.
    a_surv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_survival <= 32'h8000_0000)
        else $error("survival above one");

    // Out-of-order points carry exactly the default values.
    a_dflt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unassigned |-> o_survival == 32'h8000_0000 &&
        o_survival_std == 32'd0 && o_cum_hazard == 32'd0 &&
        o_cum_hazard_std == 32'd0 && !o_saturated)
        else $error("default result wrong");

endmodule

bind kaplan_meier_nelson_aalen kmna_chk u_kmna_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_survival       (o_survival),
    .o_survival_std   (o_survival_std),
    .o_cum_hazard     (o_cum_hazard),
    .o_cum_hazard_std (o_cum_hazard_std),
    .o_saturated      (o_saturated),
    .o_unassigned     (o_unassigned)
);
